// ----- hw/rtl/asgm_pkg.sv -----
// shared types, constants and register map of the anemometer speed and gust meter
package asgm_pkg;

  localparam int COUNT_BITS = 24;
  localparam int RES_BITS   = 24;
  localparam int MS_BITS    = 16;
  localparam int DIV_STEPS  = RES_BITS;
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  localparam logic [7:0]          DEBOUNCE_RESET      = 8'd10;
  localparam logic [MS_BITS-1:0]  GUST_INTERVAL_RESET = 16'd3000;
  localparam logic [15:0]         KMH_PER_HZ_RESET    = 16'd614;
  localparam logic [RES_BITS-1:0] RES_FULL            = 24'hFFFFFF;
  localparam logic [MS_BITS-1:0]  MS_FULL             = 16'hFFFF;
  localparam logic [9:0]          MS_PER_S            = 10'd1000;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] REG_DEBOUNCE      = 2'd0;
  localparam logic [1:0] REG_GUST_INTERVAL = 2'd1;
  localparam logic [1:0] REG_KMH_PER_HZ    = 2'd2;

  typedef struct packed {
    logic [7:0]         debounce_ms;
    logic [MS_BITS-1:0] gust_interval_ms;
    logic [15:0]        kmh_per_hz;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic mul1;
    logic mul2;
    logic check;
    logic div_step;
    logic store;
    logic load_out;
    logic sel_gust;
  } cmd_t;

  typedef struct packed {
    logic gust_due;
    logic rd_speed;
    logic skip_div;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/asgm_if.sv -----
// tick and result channel interfaces
interface asgm_tick_if;
  logic        valid;
  logic        ready;
  logic        pulse_edge;
  logic        read_speed;
  logic [23:0] elapsed_ms;
  logic        read_gust;

  modport source (output valid, pulse_edge, read_speed, elapsed_ms, read_gust, input ready);
  modport sink (input valid, pulse_edge, read_speed, elapsed_ms, read_gust, output ready);
endinterface

interface asgm_result_if;
  logic        valid;
  logic        ready;
  logic        speed_valid;
  logic [23:0] average_speed;
  logic        gust_valid;
  logic [23:0] peak_gust;

  modport source (output valid, speed_valid, average_speed, gust_valid, peak_gust, input ready);
  modport sink (input valid, speed_valid, average_speed, gust_valid, peak_gust, output ready);
endinterface

// ----- hw/rtl/asgm_ctrl.sv -----
// controller state machine: sequences tick update, conversions and result hand-off
module asgm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  asgm_pkg::status_t status,
  output asgm_pkg::cmd_t    cmd
);

  localparam int CNT_BITS = $clog2(asgm_pkg::DIV_STEPS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(asgm_pkg::DIV_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_SELECT,
    S_MUL1,
    S_MUL2,
    S_CHECK,
    S_DIV,
    S_STORE,
    S_FINISH
  } state_t;

  state_t              state;
  logic                sel_gust;
  logic [CNT_BITS-1:0] div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sel_gust <= 1'b0;
      div_cnt  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_UPDATE;
        end
        S_UPDATE: state <= S_SELECT;
        S_SELECT: begin
          if (status.gust_due) begin
            sel_gust <= 1'b1;
            state    <= S_MUL1;
          end else if (status.rd_speed) begin
            sel_gust <= 1'b0;
            state    <= S_MUL1;
          end else begin
            state <= S_FINISH;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_CHECK;
        S_CHECK: begin
          div_cnt <= '0;
          state   <= status.skip_div ? S_STORE : S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CNT_LAST) state <= S_STORE;
        end
        S_STORE: begin
          // gust evaluation first, then the speed read of the same tick
          if (sel_gust && status.rd_speed) begin
            sel_gust <= 1'b0;
            state    <= S_MUL1;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.sel_gust = sel_gust;
    case (state)
      S_IDLE:   cmd.accept   = in_valid;
      S_UPDATE: cmd.update   = 1'b1;
      S_MUL1:   cmd.mul1     = 1'b1;
      S_MUL2:   cmd.mul2     = 1'b1;
      S_CHECK:  cmd.check    = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_STORE:  cmd.store    = 1'b1;
      S_FINISH: cmd.load_out = status.out_free;
      default:  cmd.accept   = 1'b0;
    endcase
  end

  assign in_ready = (state == S_IDLE);

endmodule

// ----- hw/rtl/asgm_datapath.sv -----
// datapath: counters, multiplier chain, serial divider and result register
module asgm_datapath #(
  parameter int COUNT_BITS = asgm_pkg::COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  asgm_pkg::cfg_t                    cfg,
  input  asgm_pkg::cmd_t                    cmd,
  output asgm_pkg::status_t                 status,
  input  logic                              in_pulse_edge,
  input  logic                              in_read_speed,
  input  logic [23:0]                       in_elapsed_ms,
  input  logic                              in_read_gust,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              speed_valid,
  output logic [asgm_pkg::RES_BITS-1:0]     average_speed,
  output logic                              gust_valid,
  output logic [asgm_pkg::RES_BITS-1:0]     peak_gust
);

  localparam int RB  = asgm_pkg::RES_BITS;
  localparam int MB  = asgm_pkg::MS_BITS;
  localparam int P1W = COUNT_BITS + 16;
  localparam int PW  = P1W + 10;
  localparam int HW  = PW - RB;
  localparam int CW  = (HW > RB) ? HW : RB;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // tick state
  logic [COUNT_BITS-1:0] speed_count;
  logic [COUNT_BITS-1:0] gust_count;
  logic [MB-1:0]         ms_since_pulse;
  logic [MB-1:0]         ms_since_gust_check;
  logic [RB-1:0]         max_gust;

  // latched beat
  logic          edge_l;
  logic          rd_speed_l;
  logic [23:0]   elapsed_l;
  logic          rd_gust_l;
  logic          gust_due;

  // conversion
  logic [P1W-1:0] prod1;
  logic [PW-1:0]  prod;
  logic [RB-1:0]  divisor;
  logic [RB-1:0]  rem;
  logic [RB-1:0]  quo;
  logic [RB-1:0]  speed_res;

  logic [MB-1:0]         ms_pulse_inc;
  logic [MB-1:0]         ms_gust_inc;
  logic [MB-1:0]         interval_eff;
  logic                  accept_edge;
  logic [COUNT_BITS-1:0] speed_inc;
  logic [COUNT_BITS-1:0] gust_inc;
  logic [COUNT_BITS-1:0] mul_op;
  logic [CW-1:0]         hi_ext;
  logic [CW-1:0]         div_ext;
  logic                  div_zero;
  logic                  div_sat;
  logic [RB:0]           trial;
  logic [RB:0]           diff;
  logic                  trial_ge;

  always_comb begin
    ms_pulse_inc = (ms_since_pulse == asgm_pkg::MS_FULL) ? ms_since_pulse
                                                         : ms_since_pulse + 1'b1;
    ms_gust_inc  = (ms_since_gust_check == asgm_pkg::MS_FULL) ? ms_since_gust_check
                                                              : ms_since_gust_check + 1'b1;
    interval_eff = (cfg.gust_interval_ms == '0) ? MB'(1) : cfg.gust_interval_ms;
    accept_edge  = edge_l && (ms_pulse_inc > {8'd0, cfg.debounce_ms});
    speed_inc    = (speed_count == COUNT_MAX) ? COUNT_MAX : speed_count + 1'b1;
    gust_inc     = (gust_count == COUNT_MAX) ? COUNT_MAX : gust_count + 1'b1;
    mul_op       = cmd.sel_gust ? gust_count : speed_count;
    // quotient fits the result width only if the upper part is below the divisor
    hi_ext       = CW'(prod[PW-1:RB]);
    div_ext      = CW'(divisor);
    div_zero     = (divisor == '0);
    div_sat      = (hi_ext >= div_ext);
    trial        = {rem, quo[RB-1]};
    diff         = trial - {1'b0, divisor};
    trial_ge     = (trial >= {1'b0, divisor});
  end

  assign status.gust_due = gust_due;
  assign status.rd_speed = rd_speed_l;
  assign status.skip_div = div_zero || div_sat;
  assign status.out_free = !out_valid || out_ready;

  // control and tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_count         <= '0;
      gust_count          <= '0;
      ms_since_pulse      <= '0;
      ms_since_gust_check <= '0;
      max_gust            <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cmd.update) begin
        ms_since_gust_check <= ms_gust_inc;
        if (accept_edge) begin
          speed_count    <= speed_inc;
          gust_count     <= gust_inc;
          ms_since_pulse <= '0;
        end else begin
          ms_since_pulse <= ms_pulse_inc;
        end
      end
      if (cmd.store) begin
        if (cmd.sel_gust) begin
          if (quo > max_gust) max_gust <= quo;
          gust_count          <= '0;
          ms_since_gust_check <= '0;
        end else begin
          speed_count <= '0;
        end
      end
      if (cmd.load_out && rd_gust_l) max_gust <= '0;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      edge_l     <= in_pulse_edge;
      rd_speed_l <= in_read_speed;
      elapsed_l  <= in_elapsed_ms;
      rd_gust_l  <= in_read_gust;
    end
    if (cmd.update) gust_due <= (ms_gust_inc >= interval_eff);
    if (cmd.mul1) begin
      prod1   <= P1W'(mul_op) * P1W'(cfg.kmh_per_hz);
      divisor <= cmd.sel_gust ? RB'(interval_eff) : elapsed_l;
    end
    if (cmd.mul2) prod <= PW'(prod1) * PW'(asgm_pkg::MS_PER_S);
    if (cmd.check) begin
      if (div_zero) begin
        quo <= '0;
      end else if (div_sat) begin
        quo <= asgm_pkg::RES_FULL;
      end else begin
        rem <= hi_ext[RB-1:0];
        quo <= prod[RB-1:0];
      end
    end
    // restoring division, one quotient bit a cycle
    if (cmd.div_step) begin
      rem <= trial_ge ? diff[RB-1:0] : trial[RB-1:0];
      quo <= {quo[RB-2:0], trial_ge};
    end
    if (cmd.store && !cmd.sel_gust) speed_res <= quo;
    if (cmd.load_out) begin
      speed_valid   <= rd_speed_l;
      average_speed <= rd_speed_l ? speed_res : '0;
      gust_valid    <= rd_gust_l;
      peak_gust     <= rd_gust_l ? max_gust : '0;
    end
  end

endmodule

// ----- hw/rtl/anemometer_speed_gust_meter_top.sv -----
// top level: configuration registers, controller and datapath
// one tick beat at a time: the result register loads after the beat for a plain tick, after one
// conversion, or after a gust evaluation and a speed read together
// a new beat is taken once the result register has loaded, and the result loads only while the output is free
// each conversion is two multiplies, a range check and a serial divider that is
// skipped for zero elapsed time or a saturated result; a waiting result holds the next one back
// rst (synchronous) clears counters, peak gust and handshake state and restores register defaults
module anemometer_speed_gust_meter_top #(
  parameter int COUNT_BITS = asgm_pkg::COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  asgm_tick_if.sink                      tick,
  asgm_result_if.source                  result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [asgm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [asgm_pkg::DATA_BITS-1:0] pwdata,
  output logic [asgm_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);

  asgm_pkg::cfg_t    cfg;
  asgm_pkg::cmd_t    cmd;
  asgm_pkg::status_t status;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms      <= asgm_pkg::DEBOUNCE_RESET;
      cfg.gust_interval_ms <= asgm_pkg::GUST_INTERVAL_RESET;
      cfg.kmh_per_hz       <= asgm_pkg::KMH_PER_HZ_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        asgm_pkg::REG_DEBOUNCE:      cfg.debounce_ms      <= pwdata[7:0];
        asgm_pkg::REG_GUST_INTERVAL: cfg.gust_interval_ms <= pwdata[15:0];
        asgm_pkg::REG_KMH_PER_HZ:    cfg.kmh_per_hz       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      asgm_pkg::REG_DEBOUNCE:      prdata = {24'd0, cfg.debounce_ms};
      asgm_pkg::REG_GUST_INTERVAL: prdata = {16'd0, cfg.gust_interval_ms};
      asgm_pkg::REG_KMH_PER_HZ:    prdata = {16'd0, cfg.kmh_per_hz};
      default:                     prdata = '0;
    endcase
  end

  asgm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick.valid),
    .in_ready (tick.ready),
    .status   (status),
    .cmd      (cmd)
  );

  asgm_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .in_pulse_edge (tick.pulse_edge),
    .in_read_speed (tick.read_speed),
    .in_elapsed_ms (tick.elapsed_ms),
    .in_read_gust  (tick.read_gust),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .speed_valid   (result.speed_valid),
    .average_speed (result.average_speed),
    .gust_valid    (result.gust_valid),
    .peak_gust     (result.peak_gust)
  );

endmodule

// ----- hw/rtl/asgm_checker.sv -----
// port-level checks of the meter and their binding to the top level
module asgm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        speed_valid,
  input logic [23:0] average_speed,
  input logic        gust_valid,
  input logic [23:0] peak_gust
);

  // a result beat stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // one tick at a time: busy right after a tick beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("tick accepted while the previous one is still at work");

  a_speed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !speed_valid |-> average_speed == 24'd0)
    else $error("average speed non-zero without a speed read");

  a_gust_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !gust_valid |-> peak_gust == 24'd0)
    else $error("peak gust non-zero without a gust read");

endmodule

bind anemometer_speed_gust_meter_top asgm_checker u_asgm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (tick.valid),
  .in_ready      (tick.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .speed_valid   (result.speed_valid),
  .average_speed (result.average_speed),
  .gust_valid    (result.gust_valid),
  .peak_gust     (result.peak_gust)
);

// ----- sim/anemometer_speed_gust_meter_top_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench: random and directed ticks against a behavioural meter predictor
module anemometer_speed_gust_meter_top_tb;
  import asgm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          PHASE_TICKS  = 165;
  localparam int          SETTLE_SHORT = 8;
  localparam int          SETTLE_END   = 70;

  typedef struct packed {
    logic        pulse_edge;
    logic        read_speed;
    logic [23:0] elapsed_ms;
    logic        read_gust;
  } tick_t;

  typedef struct packed {
    logic                speed_valid;
    logic [RES_BITS-1:0] average_speed;
    logic                gust_valid;
    logic [RES_BITS-1:0] peak_gust;
  } reading_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  asgm_tick_if   tick_bus ();
  asgm_result_if result_bus ();

  anemometer_speed_gust_meter_top dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // register mirror
  logic [7:0]         cur_debounce = DEBOUNCE_RESET;
  logic [MS_BITS-1:0] cur_interval = GUST_INTERVAL_RESET;
  logic [15:0]        cur_kmh      = KMH_PER_HZ_RESET;

  // predicted meter state
  logic [COUNT_BITS-1:0] speed_pulses = '0;
  logic [COUNT_BITS-1:0] gust_pulses  = '0;
  logic [MS_BITS-1:0]    ms_pulse     = '0;
  logic [MS_BITS-1:0]    ms_gust      = '0;
  logic [RES_BITS-1:0]   peak_kmh     = '0;

  tick_t    tick_queue[$];
  reading_t expected_readings[$];

  bit          idle_on = 1'b1;
  int          failures;
  int          ticks_sent;
  int          readings_seen;
  int          speed_reads;
  int          gust_reads;
  int          saturated_reads;
  int          settings_applied;
  int unsigned cycle_count;
  int          send_gap;
  int          recv_stall;

  function automatic logic [RES_BITS-1:0] pulses_to_kmh(logic [COUNT_BITS-1:0] pulses,
                                                        logic [23:0] ms);
    logic [63:0] q;
    if (ms == '0) return '0;
    q = 64'(pulses) * 64'(cur_kmh) * 64'd1000 / 64'(ms);
    return (q > 64'(RES_FULL)) ? RES_FULL : q[RES_BITS-1:0];
  endfunction

  function automatic reading_t predict_reading(tick_t t);
    reading_t            r;
    logic [MS_BITS-1:0]  interval;
    logic [RES_BITS-1:0] g;
    r = '0;
    interval = (cur_interval == '0) ? MS_BITS'(1) : cur_interval;
    if (ms_pulse != MS_FULL) ms_pulse = ms_pulse + 1'b1;
    if (ms_gust != MS_FULL) ms_gust = ms_gust + 1'b1;
    if (t.pulse_edge && ms_pulse > MS_BITS'(cur_debounce)) begin
      if (speed_pulses != '1) speed_pulses = speed_pulses + 1'b1;
      if (gust_pulses != '1) gust_pulses = gust_pulses + 1'b1;
      ms_pulse = '0;
    end
    if (ms_gust >= interval) begin
      g = pulses_to_kmh(gust_pulses, 24'(interval));
      if (g > peak_kmh) peak_kmh = g;
      gust_pulses = '0;
      ms_gust = '0;
    end
    if (t.read_speed) begin
      r.speed_valid = 1'b1;
      r.average_speed = pulses_to_kmh(speed_pulses, t.elapsed_ms);
      speed_pulses = '0;
    end
    if (t.read_gust) begin
      r.gust_valid = 1'b1;
      r.peak_gust = peak_kmh;
      peak_kmh = '0;
    end
    return r;
  endfunction

  function automatic tick_t random_tick(int unsigned pulse_pct);
    tick_t t;
    t.pulse_edge = ($urandom_range(0, 99) < pulse_pct);
    t.read_speed = ($urandom_range(0, 9) == 0);
    t.read_gust  = ($urandom_range(0, 11) == 0);
    case ($urandom_range(0, 5))
      0: t.elapsed_ms = '0;
      1: t.elapsed_ms = '1;
      2: t.elapsed_ms = 24'($urandom_range(1, 16));
      3, 4: t.elapsed_ms = 24'($urandom_range(1, 5000));
      default: t.elapsed_ms = 24'($urandom);
    endcase
    return t;
  endfunction

  task automatic push_tick(input logic edge_in, input logic rd_speed, input logic [23:0] ms,
                           input logic rd_gust);
    tick_t t;
    t = '{edge_in, rd_speed, ms, rd_gust};
    tick_queue.push_back(t);
  endtask

  // checked on the falling edge so the driver's and monitor's updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (tick_queue.size() != 0 || tick_bus.valid || expected_readings.size() != 0)
      @(negedge clk);
  endtask

  task automatic quiesce(input int cycles);
    wait_drained();
    repeat (cycles) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic is_write, input logic [1:0] idx,
                              input logic [DATA_BITS-1:0] wdata,
                              output logic [DATA_BITS-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] deb, input logic [15:0] intv,
                                input logic [15:0] kmh);
    logic [1:0]           regs [3];
    logic [DATA_BITS-1:0] vals [3];
    logic [DATA_BITS-1:0] masks [3];
    logic [DATA_BITS-1:0] rd;
    regs  = '{REG_DEBOUNCE, REG_GUST_INTERVAL, REG_KMH_PER_HZ};
    vals  = '{DATA_BITS'(deb), DATA_BITS'(intv), DATA_BITS'(kmh)};
    masks = '{DATA_BITS'(8'hFF), DATA_BITS'(16'hFFFF), DATA_BITS'(16'hFFFF)};
    for (int i = 0; i < 3; i++) apb_transfer(1'b1, regs[i], vals[i], rd);
    cur_debounce = deb;
    cur_interval = intv;
    cur_kmh      = kmh;
    settings_applied++;
    for (int i = 0; i < 3; i++) begin
      apb_transfer(1'b0, regs[i], '0, rd);
      if ((rd & masks[i]) !== vals[i]) begin
        failures++;
        if (failures <= 10)
          $display("register %0d read back %0h, expected %0h", regs[i], rd & masks[i], vals[i]);
      end
    end
  endtask

  // hold-off half way through so every reading drains before the rest is sent
  task automatic random_ticks(input int n, input int unsigned pulse_pct);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();
      tick_queue.push_back(random_tick(pulse_pct));
    end
  endtask

  // tick driver
  always @(posedge clk) begin : drive_ticks
    tick_t tk;
    if (rst) begin
      tick_bus.valid      <= 1'b0;
      tick_bus.pulse_edge <= 1'b0;
      tick_bus.read_speed <= 1'b0;
      tick_bus.elapsed_ms <= '0;
      tick_bus.read_gust  <= 1'b0;
      send_gap <= 0;
    end else begin
      if (tick_bus.valid && tick_bus.ready) begin
        tk = '{tick_bus.pulse_edge, tick_bus.read_speed, tick_bus.elapsed_ms,
               tick_bus.read_gust};
        expected_readings.push_back(predict_reading(tk));
        ticks_sent++;
      end
      if (!tick_bus.valid || tick_bus.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          tick_bus.valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          if (idle_on && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 3);
            tick_bus.valid <= 1'b0;
          end else begin
            tk = tick_queue.pop_front();
            tick_bus.pulse_edge <= tk.pulse_edge;
            tick_bus.read_speed <= tk.read_speed;
            tick_bus.elapsed_ms <= tk.elapsed_ms;
            tick_bus.read_gust  <= tk.read_gust;
            tick_bus.valid      <= 1'b1;
          end
        end else begin
          tick_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : check_readings
    reading_t got;
    reading_t want;
    if (rst) begin
      result_bus.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        got = '{result_bus.speed_valid, result_bus.average_speed, result_bus.gust_valid,
                result_bus.peak_gust};
        readings_seen++;
        if (expected_readings.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("reading beat with nothing outstanding: speed %0b/%0d gust %0b/%0d",
                     got.speed_valid, got.average_speed, got.gust_valid, got.peak_gust);
        end else begin
          want = expected_readings.pop_front();
          if (want.speed_valid) speed_reads++;
          if (want.gust_valid) gust_reads++;
          if ((want.speed_valid && want.average_speed == RES_FULL) ||
              (want.gust_valid && want.peak_gust == RES_FULL))
            saturated_reads++;
          if (got.speed_valid !== want.speed_valid || got.average_speed !== want.average_speed ||
              got.gust_valid !== want.gust_valid || got.peak_gust !== want.peak_gust) begin
            failures++;
            if (failures <= 10)
              $display({"reading %0d: expected speed %0b/%0d gust %0b/%0d, ",
                        "got speed %0b/%0d gust %0b/%0d"},
                       readings_seen, want.speed_valid, want.average_speed, want.gust_valid,
                       want.peak_gust, got.speed_valid, got.average_speed, got.gust_valid,
                       got.peak_gust);
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        result_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        recv_stall <= $urandom_range(0, 3);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout: %0d ticks queued, %0d readings outstanding", tick_queue.size(),
               expected_readings.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: early edge, zero elapsed time, full-scale elapsed time
    push_tick(1'b1, 1'b0, 24'd0, 1'b0);
    push_tick(1'b0, 1'b1, 24'd0, 1'b0);
    push_tick(1'b0, 1'b0, 24'd0, 1'b1);
    push_tick(1'b1, 1'b1, '1, 1'b1);
    repeat (6) push_tick(1'b0, 1'b0, 24'($urandom), 1'b0);
    push_tick(1'b1, 1'b0, 24'd0, 1'b0);
    push_tick(1'b1, 1'b0, 24'd0, 1'b0);
    push_tick(1'b0, 1'b1, 24'd1, 1'b0);
    push_tick(1'b1, 1'b1, 24'd0, 1'b1);
    quiesce(SETTLE_SHORT);

    // no debounce, 1 ms gust window, top scale factor: both readings saturate
    apply_settings(8'd0, 16'd1, 16'hFFFF);
    push_tick(1'b1, 1'b0, 24'd0, 1'b1);
    push_tick(1'b1, 1'b1, 24'd1, 1'b1);
    push_tick(1'b1, 1'b1, '1, 1'b0);
    random_ticks(PHASE_TICKS, 70);
    quiesce(SETTLE_SHORT);

    apply_settings(8'hFF, 16'hFFFF, 16'd0);
    random_ticks(PHASE_TICKS, 50);
    quiesce(SETTLE_SHORT);

    // gust interval of zero behaves as 1 ms
    apply_settings(8'd0, 16'd0, KMH_PER_HZ_RESET);
    random_ticks(PHASE_TICKS, 40);
    quiesce(SETTLE_SHORT);

    for (int p = 0; p < 4; p++) begin
      apply_settings(8'($urandom_range(0, 12)), 16'($urandom_range(1, 300)), 16'($urandom));
      random_ticks(PHASE_TICKS, 50);
      quiesce(SETTLE_SHORT);
    end

    // closing phase runs with no idling on either side
    idle_on = 1'b0;
    apply_settings(8'($urandom_range(0, 8)), 16'($urandom_range(1, 100)), 16'($urandom));
    random_ticks(PHASE_TICKS, 50);
    quiesce(SETTLE_END);

    $display("%0d ticks over %0d register settings, %0d readings checked", ticks_sent,
             settings_applied, readings_seen);
    $display("%0d speed reads, %0d gust reads, %0d saturated, %0d mismatches", speed_reads,
             gust_reads, saturated_reads, failures);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/asgm_pkg.sv
hw/rtl/asgm_if.sv
hw/rtl/asgm_ctrl.sv
hw/rtl/asgm_datapath.sv
hw/rtl/anemometer_speed_gust_meter_top.sv
hw/rtl/asgm_checker.sv
sim/anemometer_speed_gust_meter_top_tb.sv
